FILE: hw/rtl/dur_pkg.sv
// Shared types, register map and reset values of the dual ultrasonic ranger.
package dur_pkg;

	localparam int unsigned AddrWidth = 5;
	localparam int unsigned DataWidth = 32;
	localparam int unsigned MmWidth   = 14;

	localparam int unsigned DefChannels   = 2;
	localparam int unsigned DefTrigHighUs = 10;
	localparam int unsigned DefTrigPreUs  = 5;

	localparam logic [2:0] REG_RUN_ENABLE = 3'd0;
	localparam logic [2:0] REG_TIMEOUT    = 3'd1;
	localparam logic [2:0] REG_INTERVAL   = 3'd2;
	localparam logic [2:0] REG_SCALE      = 3'd3;
	localparam logic [2:0] REG_MIN_MM     = 3'd4;
	localparam logic [2:0] REG_MAX_MM     = 3'd5;

	localparam logic [15:0] RST_TIMEOUT  = 16'd12000;
	localparam logic [9:0]  RST_INTERVAL = 10'd100;
	localparam logic [15:0] RST_SCALE    = 16'd11246;
	localparam logic [13:0] RST_MIN_MM   = 14'd30;
	localparam logic [13:0] RST_MAX_MM   = 14'd3800;

	typedef struct packed {
		logic        run_enable;
		logic [15:0] timeout_ticks;
		logic [9:0]  gap_ms;
		logic [15:0] scale_q16;
		logic [13:0] min_mm;
		logic [13:0] max_mm;
	} dur_cfg_t;

	typedef struct packed {
		logic echo_level0;
		logic echo_level1;
	} dur_echo_t;

	typedef struct packed {
		logic        trigger0;
		logic        trigger1;
		logic        measure_done;
		logic        done_channel;
		logic        timed_out;
		logic [13:0] distance_mm;
		logic [13:0] latest_mm0;
		logic        latest_ok0;
		logic [13:0] latest_mm1;
		logic        latest_ok1;
	} dur_res_t;

endpackage

FILE: hw/rtl/dur_if.sv
// Valid/ready channel interfaces for echo samples and ranging results.
interface dur_in_if;
	logic valid;
	logic ready;
	logic echo_level0;
	logic echo_level1;

	modport source (output valid, output echo_level0, output echo_level1, input ready);
	modport sink (input valid, input echo_level0, input echo_level1, output ready);
endinterface

interface dur_out_if;
	logic        valid;
	logic        ready;
	logic        trigger0;
	logic        trigger1;
	logic        measure_done;
	logic        done_channel;
	logic        timed_out;
	logic [13:0] distance_mm;
	logic [13:0] latest_mm0;
	logic        latest_ok0;
	logic [13:0] latest_mm1;
	logic        latest_ok1;

	modport source (
		output valid, output trigger0, output trigger1, output measure_done,
		output done_channel, output timed_out, output distance_mm,
		output latest_mm0, output latest_ok0, output latest_mm1, output latest_ok1,
		input ready
	);
	modport sink (
		input valid, input trigger0, input trigger1, input measure_done,
		input done_channel, input timed_out, input distance_mm,
		input latest_mm0, input latest_ok0, input latest_mm1, input latest_ok1,
		output ready
	);
endinterface

FILE: hw/rtl/dual_ultrasonic_ranger_top.sv
// Top level of the dual ultrasonic ranger: register file, sequencer and result register.
//
//  Channel   Dir  Payload                                        Transfer
//  tick      in   echo_level0, echo_level1                       valid && ready
//  result    out  trigger0/1, measure_done, done_channel,        valid && ready
//                 timed_out, distance_mm, latest_mm0/1, ok0/1
//  APB       in   run_enable .. max_mm at 4*i                    psel && penable && pwrite
//
// One tick per cycle while no result is stalled; its result is loaded into the result register on the transfer edge.
// The sequencer state updates on the tick transfer edge; scaling is one 16x16 multiply.
// A result waiting on a stalled sink blocks the next tick only while it is not taken.
// Reset clears all sequencer state and loads the register defaults; no clearing pass.
module dual_ultrasonic_ranger_top #(
	parameter int unsigned CHANNELS           = dur_pkg::DefChannels,
	parameter int unsigned TRIGGER_HIGH_US    = dur_pkg::DefTrigHighUs,
	parameter int unsigned TRIGGER_PRE_LOW_US = dur_pkg::DefTrigPreUs
) (
	input  logic                            clk,
	input  logic                            arst_n,
	dur_in_if.sink                          tick,
	dur_out_if.source                       result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dur_pkg::AddrWidth-1:0]   paddr,
	input  logic [dur_pkg::DataWidth-1:0]   pwdata,
	output logic [dur_pkg::DataWidth-1:0]   prdata,
	output logic                            pready
);
	import dur_pkg::*;

	dur_cfg_t  cfg_q;
	dur_echo_t echo;
	dur_res_t  res;
	dur_res_t  res_q;
	logic      res_vld_q;
	logic      step;
	logic      wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[AddrWidth-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_enable    <= 1'b0;
			cfg_q.timeout_ticks <= RST_TIMEOUT;
			cfg_q.gap_ms        <= RST_INTERVAL;
			cfg_q.scale_q16     <= RST_SCALE;
			cfg_q.min_mm        <= RST_MIN_MM;
			cfg_q.max_mm        <= RST_MAX_MM;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_RUN_ENABLE: cfg_q.run_enable    <= pwdata[0];
				REG_TIMEOUT:    cfg_q.timeout_ticks <= pwdata[15:0];
				REG_INTERVAL:   cfg_q.gap_ms        <= pwdata[9:0];
				REG_SCALE:      cfg_q.scale_q16     <= pwdata[15:0];
				REG_MIN_MM:     cfg_q.min_mm        <= pwdata[13:0];
				REG_MAX_MM:     cfg_q.max_mm        <= pwdata[13:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RUN_ENABLE: prdata = {31'd0, cfg_q.run_enable};
			REG_TIMEOUT:    prdata = {16'd0, cfg_q.timeout_ticks};
			REG_INTERVAL:   prdata = {22'd0, cfg_q.gap_ms};
			REG_SCALE:      prdata = {16'd0, cfg_q.scale_q16};
			REG_MIN_MM:     prdata = {18'd0, cfg_q.min_mm};
			REG_MAX_MM:     prdata = {18'd0, cfg_q.max_mm};
			default:        prdata = '0;
		endcase
	end

	assign tick.ready       = !res_vld_q || result.ready;
	assign step             = tick.valid && tick.ready;
	assign echo.echo_level0 = tick.echo_level0;
	assign echo.echo_level1 = tick.echo_level1;

	dur_core #(
		.CHANNELS           (CHANNELS),
		.TRIGGER_HIGH_US    (TRIGGER_HIGH_US),
		.TRIGGER_PRE_LOW_US (TRIGGER_PRE_LOW_US)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.echo   (echo),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (step) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign result.valid        = res_vld_q;
	assign result.trigger0     = res_q.trigger0;
	assign result.trigger1     = res_q.trigger1;
	assign result.measure_done = res_q.measure_done;
	assign result.done_channel = res_q.done_channel;
	assign result.timed_out    = res_q.timed_out;
	assign result.distance_mm  = res_q.distance_mm;
	assign result.latest_mm0   = res_q.latest_mm0;
	assign result.latest_ok0   = res_q.latest_ok0;
	assign result.latest_mm1   = res_q.latest_mm1;
	assign result.latest_ok1   = res_q.latest_ok1;

	a_one_trigger: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.trigger0 && result.trigger1))
		else $error("both trigger lines high");

	a_timeout_form: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.timed_out) |-> (result.measure_done && result.distance_mm == '0))
		else $error("timeout without done or with distance");

	a_chan_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.done_channel) |-> result.measure_done)
		else $error("done channel set without completion");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |-> !tick.ready)
		else $error("tick taken while result stalled");

endmodule

FILE: hw/rtl/dur_core.sv
// Ranging sequencer: trigger timing, echo wait and width timing, distance scaling and clamping, interval gap.
module dur_core #(
	parameter int unsigned CHANNELS        = 2,
	parameter int unsigned TRIGGER_HIGH_US = 10,
	parameter int unsigned TRIGGER_PRE_LOW_US = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  dur_pkg::dur_echo_t echo,
	input  dur_pkg::dur_cfg_t  cfg,
	output dur_pkg::dur_res_t  res
);
	import dur_pkg::*;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_PRE  = 3'd1;
	localparam logic [2:0] PH_HIGH = 3'd2;
	localparam logic [2:0] PH_END  = 3'd3;
	localparam logic [2:0] PH_RISE = 3'd4;
	localparam logic [2:0] PH_MEAS = 3'd5;
	localparam logic [2:0] PH_GAP  = 3'd6;

	localparam logic [3:0] PreTicks  = 4'(TRIGGER_PRE_LOW_US);
	localparam logic [3:0] HighTicks = 4'(TRIGGER_HIGH_US);
	localparam logic [2:0] StartPh   = (TRIGGER_PRE_LOW_US == 0) ? PH_HIGH : PH_PRE;
	localparam logic       TwoCh     = (CHANNELS >= 2);

	logic [2:0]  phase_q, phase_d;
	logic        chan_q, chan_d;
	logic [3:0]  pticks_q, pticks_d;
	logic [15:0] wait_q, wait_d;
	logic [15:0] width_q, width_d;
	logic [19:0] ival_q, ival_d;
	logic [13:0] dist_q [2];
	logic [13:0] dist_d [2];
	logic [1:0]  ok_q, ok_d;

	logic        echo_cur;
	logic [19:0] ival_lim;
	logic [31:0] prod;
	logic [15:0] dscaled;
	logic [13:0] dclamp;
	logic        finish;

	assign echo_cur = chan_q ? echo.echo_level1 : echo.echo_level0;
	assign ival_lim = {10'd0, cfg.gap_ms} * 20'd1000;
	assign prod     = 32'(width_q) * 32'(cfg.scale_q16);
	assign dscaled  = prod[31:16];

	always_comb begin
		if (dscaled < {2'b00, cfg.min_mm}) begin
			dclamp = '0;
		end else if (dscaled > {2'b00, cfg.max_mm}) begin
			dclamp = cfg.max_mm;
		end else begin
			dclamp = dscaled[13:0];
		end
	end

	always_comb begin
		phase_d  = phase_q;
		chan_d   = chan_q;
		pticks_d = pticks_q;
		wait_d   = wait_q;
		width_d  = width_q;
		ival_d   = ival_q;
		dist_d   = dist_q;
		ok_d     = ok_q;
		finish   = 1'b0;
		res      = '0;

		unique case (phase_q)
			PH_PRE: begin
				pticks_d = pticks_q + 4'd1;
				if (pticks_d >= PreTicks) begin
					phase_d  = PH_HIGH;
					pticks_d = '0;
				end
			end
			PH_HIGH: begin
				res.trigger0 = !chan_q;
				res.trigger1 = chan_q;
				pticks_d = pticks_q + 4'd1;
				if (pticks_d >= HighTicks) begin
					phase_d  = PH_END;
					pticks_d = '0;
					wait_d   = '0;
					width_d  = '0;
				end
			end
			PH_END, PH_RISE, PH_MEAS: begin
				if (wait_q != 16'hFFFF) begin
					wait_d = wait_q + 16'd1;
				end
				if (phase_q == PH_END) begin
					if (!echo_cur) begin
						phase_d = PH_RISE;
					end
				end else if (phase_q == PH_RISE) begin
					if (echo_cur) begin
						phase_d = PH_MEAS;
						width_d = 16'd1;
					end
				end else if (echo_cur) begin
					if (width_q != 16'hFFFF) begin
						width_d = width_q + 16'd1;
					end
				end else begin
					res.measure_done = 1'b1;
					res.distance_mm  = dclamp;
					dist_d[chan_q]   = dclamp;
					ok_d[chan_q]     = 1'b1;
					finish           = 1'b1;
				end
				if (!finish && wait_d >= cfg.timeout_ticks) begin
					res.measure_done = 1'b1;
					res.timed_out    = 1'b1;
					ok_d[chan_q]     = 1'b0;
					finish           = 1'b1;
				end
				if (finish) begin
					res.done_channel = chan_q;
					if (!chan_q && TwoCh) begin
						chan_d   = 1'b1;
						pticks_d = '0;
						phase_d  = StartPh;
					end else begin
						phase_d = PH_GAP;
						ival_d  = '0;
					end
				end
			end
			PH_GAP: begin
				ival_d = ival_q + 20'd1;
				if (ival_d >= ival_lim) begin
					ival_d = '0;
					if (cfg.run_enable) begin
						chan_d   = 1'b0;
						pticks_d = '0;
						phase_d  = StartPh;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (cfg.run_enable) begin
					chan_d   = 1'b0;
					pticks_d = '0;
					phase_d  = StartPh;
				end
			end
		endcase

		res.latest_mm0 = dist_d[0];
		res.latest_ok0 = ok_d[0];
		res.latest_mm1 = dist_d[1];
		res.latest_ok1 = ok_d[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			chan_q   <= 1'b0;
			pticks_q <= '0;
			wait_q   <= '0;
			width_q  <= '0;
			ival_q   <= '0;
			dist_q   <= '{default: '0};
			ok_q     <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			chan_q   <= chan_d;
			pticks_q <= pticks_d;
			wait_q   <= wait_d;
			width_q  <= width_d;
			ival_q   <= ival_d;
			dist_q   <= dist_d;
			ok_q     <= ok_d;
		end
	end

endmodule
